@@ sv/cds_pkg.sv @@
// Shared types, constants and calendar helpers for the date shift unit.
`default_nettype none

package cds_pkg;

  localparam int unsigned MONTHS       = 12;
  localparam int unsigned LEAP_CYCLE   = 400;
  localparam int unsigned CENTURY      = 100;
  localparam int unsigned FEB_LEAP_LEN = 29;
  localparam int unsigned FEBRUARY     = 2;

  localparam logic [4:0] MONTH_LEN_TAB [0:12] = '{
    5'd0, 5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
    5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
  };

  typedef enum logic {
    OP_ADD,
    OP_SUB
  } unit_op_e;

  typedef struct packed {
    logic neg;
    logic zero;
    logic pos;
  } unit_flags_t;

  // Leap test from the two low year bits and the year modulo 400.
  function automatic logic is_leap(input logic [1:0] year_lo, input logic [8:0] rem400);
    logic century;
    century = (rem400 == 9'(CENTURY)) || (rem400 == 9'(2 * CENTURY)) ||
              (rem400 == 9'(3 * CENTURY));
    return ((year_lo == 2'b00) && !century) || (rem400 == 9'd0);
  endfunction

  // Days in a month; zero for a month code outside 1..12.
  function automatic logic [4:0] month_len(input logic [3:0] month, input logic leap);
    logic [4:0] len;
    if (month == 4'd0 || month > 4'(MONTHS)) begin
      len = 5'd0;
    end else if (month == 4'(FEBRUARY) && leap) begin
      len = 5'(FEB_LEAP_LEN);
    end else begin
      len = MONTH_LEN_TAB[month];
    end
    return len;
  endfunction

endpackage

`default_nettype wire

@@ sv/cds_addsub.sv @@
// Shared add/subtract unit with sign and zero flags.
`default_nettype none

module cds_addsub #(
  parameter int unsigned AW = 18
) (
  input  logic signed [AW-1:0] a_i,
  input  logic signed [AW-1:0] b_i,
  input  cds_pkg::unit_op_e    op_i,
  output logic signed [AW-1:0] sum_o,
  output cds_pkg::unit_flags_t flags_o
);
  import cds_pkg::*;

  // Form the sum or difference
  always_comb begin
    case (op_i)
      OP_SUB:  sum_o = a_i - b_i;
      default: sum_o = a_i + b_i;
    endcase
  end

  // Classify the result
  assign flags_o.neg  = sum_o[AW-1];
  assign flags_o.zero = (sum_o == '0);
  assign flags_o.pos  = !sum_o[AW-1] && (sum_o != '0);

endmodule

`default_nettype wire

@@ sv/calendar_date_shift_unit.sv @@
// Top level of the Gregorian date shift unit: sequencer, state and result registers.
`default_nettype none

// Adds a signed day offset to a Gregorian date, one request at a time. A request
// first reduces the year modulo 400 by repeated subtraction (skipped for a year
// beyond the limit), then checks the date and applies the offset, then steps one
// month per cycle until the day fits its month, and finally holds the result until
// it is taken. All of this runs through one shared add/subtract unit (an invalid
// date skips the month steps), and the next request is taken only after the result
// has been taken; in_ready_o is low meanwhile. An invalid start date returns zeros
// with input_valid_o low; a result beyond the year range saturates and raises
// out_of_range_o.
module calendar_date_shift_unit #(
  parameter int unsigned MAX_SHIFT  = 65535,
  parameter int unsigned YEAR_LIMIT = 9999
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [13:0]        year_in_i,
  input  logic [3:0]         month_in_i,
  input  logic [4:0]         day_in_i,
  input  logic signed [16:0] day_offset_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [13:0]        year_out_o,
  output logic [3:0]         month_out_o,
  output logic [4:0]         day_out_o,
  output logic               input_valid_o,
  output logic               out_of_range_o
);
  import cds_pkg::*;

  localparam int unsigned YW_MIN = $clog2(YEAR_LIMIT + 2);
  localparam int unsigned YW     = (YW_MIN > 14) ? YW_MIN : 14;
  localparam int unsigned DW     = $clog2(MAX_SHIFT + 64) + 1;
  localparam int unsigned AW     = (DW > YW + 1) ? DW : YW + 1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MOD,
    ST_CHECK,
    ST_STEP,
    ST_DONE
  } state_e;

  state_e               state_q;
  logic [YW-1:0]        year_q;
  logic [YW-1:0]        rem_q;
  logic [3:0]           month_q;
  logic signed [DW-1:0] day_q;
  logic [DW-1:0]        mag_q;
  logic                 neg_q;

  logic [13:0]          year_out_q;
  logic [3:0]           month_out_q;
  logic [4:0]           day_out_q;
  logic                 valid_out_q;
  logic                 range_out_q;

  logic [16:0]          mag_raw;
  logic [DW-1:0]        mag_sat;
  logic                 in_acc;

  logic [8:0]           rem400;
  logic                 leap_cur;
  logic [4:0]           len_cur;
  logic                 date_ok;

  logic [3:0]           month_fwd;
  logic [YW-1:0]        year_fwd;
  logic [8:0]           rem_fwd;
  logic                 wrap_fwd;
  logic [3:0]           month_bwd;
  logic [YW-1:0]        year_bwd;
  logic [8:0]           rem_bwd;
  logic                 wrap_bwd;
  logic [4:0]           len_bwd;

  logic signed [AW-1:0] op_a;
  logic signed [AW-1:0] op_b;
  unit_op_e             op_sel;
  logic signed [AW-1:0] sum;
  unit_flags_t          flags;

  assign in_acc     = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == ST_IDLE);

  // Take the offset magnitude and clamp it to the shift limit
  assign mag_raw = day_offset_i[16] ? (~day_offset_i + 17'd1) : day_offset_i;
  assign mag_sat = (32'(mag_raw) > 32'(MAX_SHIFT)) ? DW'(MAX_SHIFT) : DW'(mag_raw);

  // Month length and validity of the current date
  assign rem400   = rem_q[8:0];
  assign leap_cur = is_leap(year_q[1:0], rem400);
  assign len_cur  = month_len(month_q, leap_cur);
  assign date_ok  = (year_q <= YW'(YEAR_LIMIT)) && (month_q != 4'd0) &&
                    (month_q <= 4'(MONTHS)) && (day_q > 0) &&
                    (day_q <= DW'(len_cur));

  // Next and previous month, with year and modulo-400 wrap
  always_comb begin
    wrap_fwd  = (month_q == 4'(MONTHS));
    month_fwd = wrap_fwd ? 4'd1 : month_q + 4'd1;
    year_fwd  = wrap_fwd ? year_q + YW'(1) : year_q;
    rem_fwd   = rem400;
    if (wrap_fwd) begin
      rem_fwd = (rem400 == 9'(LEAP_CYCLE - 1)) ? 9'd0 : rem400 + 9'd1;
    end
    wrap_bwd  = (month_q <= 4'd1);
    month_bwd = wrap_bwd ? 4'(MONTHS) : month_q - 4'd1;
    year_bwd  = wrap_bwd ? year_q - YW'(1) : year_q;
    rem_bwd   = rem400;
    if (wrap_bwd) begin
      rem_bwd = (rem400 == 9'd0) ? 9'(LEAP_CYCLE - 1) : rem400 - 9'd1;
    end
    len_bwd   = month_len(month_bwd, is_leap(year_bwd[1:0], rem_bwd));
  end

  // Select operands for the shared unit
  always_comb begin
    op_a   = AW'(day_q);
    op_b   = AW'(len_cur);
    op_sel = OP_SUB;
    unique case (state_q)
      ST_MOD: begin
        op_a   = AW'(rem_q);
        op_b   = AW'(LEAP_CYCLE);
        op_sel = OP_SUB;
      end
      ST_CHECK: begin
        op_a   = AW'(day_q);
        op_b   = AW'(mag_q);
        op_sel = neg_q ? OP_SUB : OP_ADD;
      end
      ST_STEP: begin
        op_a   = AW'(day_q);
        op_b   = neg_q ? AW'(len_bwd) : AW'(len_cur);
        op_sel = neg_q ? OP_ADD : OP_SUB;
      end
      default: begin
        op_a   = AW'(day_q);
        op_b   = AW'(len_cur);
        op_sel = OP_SUB;
      end
    endcase
  end

  cds_addsub #(
    .AW(AW)
  ) u_addsub (
    .a_i    (op_a),
    .b_i    (op_b),
    .op_i   (op_sel),
    .sum_o  (sum),
    .flags_o(flags)
  );

  // Sequencer, working registers and result registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      year_q      <= '0;
      rem_q       <= '0;
      month_q     <= '0;
      day_q       <= '0;
      mag_q       <= '0;
      neg_q       <= 1'b0;
      year_out_q  <= '0;
      month_out_q <= '0;
      day_out_q   <= '0;
      valid_out_q <= 1'b0;
      range_out_q <= 1'b0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            year_q  <= YW'(year_in_i);
            rem_q   <= YW'(year_in_i);
            month_q <= month_in_i;
            day_q   <= DW'(day_in_i);
            mag_q   <= mag_sat;
            neg_q   <= day_offset_i[16];
            state_q <= ST_MOD;
          end
        end
        ST_MOD: begin
          // Reduce the year modulo 400; skip for an out-of-range year
          if (year_q > YW'(YEAR_LIMIT)) begin
            state_q <= ST_CHECK;
          end else if (!flags.neg) begin
            rem_q <= sum[YW-1:0];
          end else begin
            state_q <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          if (!date_ok) begin
            year_out_q  <= '0;
            month_out_q <= '0;
            day_out_q   <= '0;
            valid_out_q <= 1'b0;
            range_out_q <= 1'b0;
            state_q     <= ST_DONE;
          end else begin
            day_q   <= sum[DW-1:0];
            state_q <= ST_STEP;
          end
        end
        ST_STEP: begin
          valid_out_q <= 1'b1;
          if (!neg_q) begin
            // Forward: drop whole months while the day exceeds its month
            if (!flags.pos) begin
              year_out_q  <= year_q[13:0];
              month_out_q <= month_q;
              day_out_q   <= day_q[4:0];
              range_out_q <= 1'b0;
              state_q     <= ST_DONE;
            end else if (wrap_fwd && (year_fwd > YW'(YEAR_LIMIT))) begin
              year_out_q  <= 14'(YEAR_LIMIT);
              month_out_q <= 4'(MONTHS);
              day_out_q   <= 5'd31;
              range_out_q <= 1'b1;
              state_q     <= ST_DONE;
            end else begin
              day_q   <= sum[DW-1:0];
              month_q <= month_fwd;
              year_q  <= year_fwd;
              rem_q   <= YW'(rem_fwd);
            end
          end else begin
            // Backward: add back whole months while the day is not positive
            if (day_q > 0) begin
              year_out_q  <= year_q[13:0];
              month_out_q <= month_q;
              day_out_q   <= day_q[4:0];
              range_out_q <= 1'b0;
              state_q     <= ST_DONE;
            end else if (wrap_bwd && (year_q == '0)) begin
              year_out_q  <= '0;
              month_out_q <= 4'd1;
              day_out_q   <= 5'd1;
              range_out_q <= 1'b1;
              state_q     <= ST_DONE;
            end else begin
              day_q   <= sum[DW-1:0];
              month_q <= month_bwd;
              year_q  <= year_bwd;
              rem_q   <= YW'(rem_bwd);
            end
          end
        end
        ST_DONE: begin
          if (out_ready_i) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o    = (state_q == ST_DONE);
  assign year_out_o     = year_out_q;
  assign month_out_o    = month_out_q;
  assign day_out_o      = day_out_q;
  assign input_valid_o  = valid_out_q;
  assign out_of_range_o = range_out_q;

`ifndef NO_ASSERTIONS
  a_busy_while_holding : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o)
    else $error("input taken while a result is pending");

  a_one_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i) |=> !out_valid_o)
    else $error("result repeated after delivery");

  a_invalid_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !input_valid_o) |-> (month_out_o == 4'd0 && day_out_o == 5'd0 &&
                                         !out_of_range_o))
    else $error("invalid date result not cleared");

  a_month_legal : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && input_valid_o) |-> (month_out_o != 4'd0 && month_out_o <= 4'(MONTHS) &&
                                        day_out_o != 5'd0))
    else $error("valid result with illegal month or day");
`endif

endmodule

`default_nettype wire
